// ----- sv/letok_pkg.sv -----
package letok_pkg;

  typedef enum logic [9:0] {
    ST_START   = 10'b00_0000_0001,
    ST_KEY     = 10'b00_0000_0010,
    ST_PREEQ   = 10'b00_0000_0100,
    ST_PREVAL  = 10'b00_0000_1000,
    ST_QUOTED  = 10'b00_0001_0000,
    ST_BARE    = 10'b00_0010_0000,
    ST_POSTVAL = 10'b00_0100_0000,
    ST_UNIT    = 10'b00_1000_0000,
    ST_POSTUNT = 10'b01_0000_0000,
    ST_CR      = 10'b10_0000_0000
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_DROP  = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_VALUE = 2'd2,
    KIND_UNIT  = 2'd3
  } char_kind_e;

  typedef enum logic [1:0] {
    HALT_RUN    = 2'd0,
    HALT_SYNTAX = 2'd1,
    HALT_EOI    = 2'd2
  } halt_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  function automatic logic is_space(input logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

  function automatic logic is_graph(input logic [7:0] c);
    return (c >= 8'd33) && (c <= 8'd126);
  endfunction

endpackage

// ----- sv/letok_if.sv -----
interface letok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface letok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] char_kind;
  logic       element_done;
  logic [1:0] halt_status;

  modport source (output valid, output out_char, output char_kind, output element_done,
                  output halt_status, input ready);
  modport sink   (input valid, input out_char, input char_kind, input element_done,
                  input halt_status, output ready);
endinterface

// ----- sv/label_element_tokenizer_unit.sv -----
// An accepted input word passes two registers on its way to its result word (input
// register, then the result register fed by the parser's next-state logic).
// Throughput: one word per cycle while out_o.ready stays high; a low ready stalls both stages.
// Reset (rst_ni low, async): parser returns to start-of-element, halt cleared,
// both pipeline stages empty.
module label_element_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  letok_in_if.sink    in_i,
  letok_out_if.source out_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_eoi_q;

  letok_pkg::parse_state_e state_q, state_d;
  letok_pkg::halt_e        halt_q, halt_d;

  logic                   out_valid_q;
  logic [7:0]             out_char_q, out_char_d;
  letok_pkg::char_kind_e  kind_q, kind_d;
  logic                   done_q, done_d;
  letok_pkg::halt_e       status_q;

  logic s2_ready;
  logic advance;

  assign s2_ready = !out_valid_q || out_o.ready;
  assign advance  = s1_valid_q && s2_ready;
  assign in_i.ready = !s1_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.in_byte;
      s1_eoi_q  <= in_i.end_of_input;
    end
  end

  always_comb begin
    logic [7:0]              c;
    letok_pkg::parse_state_e nxt;
    letok_pkg::char_kind_e   kind;
    logic                    done;
    logic                    bad;

    c    = s1_byte_q;
    nxt  = state_q;
    kind = letok_pkg::KIND_DROP;
    done = 1'b0;
    bad  = 1'b0;

    case (state_q)
      letok_pkg::ST_KEY: begin
        if (letok_pkg::is_space(c)) nxt = letok_pkg::ST_PREEQ;
        else if (letok_pkg::is_alpha(c) || c == letok_pkg::CH_UNDER) kind = letok_pkg::KIND_KEY;
        else bad = 1'b1;
      end
      letok_pkg::ST_PREEQ: begin
        if (letok_pkg::is_space(c)) nxt = letok_pkg::ST_PREEQ;
        else if (c == letok_pkg::CH_EQ) nxt = letok_pkg::ST_PREVAL;
        else bad = 1'b1;
      end
      letok_pkg::ST_PREVAL: begin
        if (letok_pkg::is_space(c)) nxt = letok_pkg::ST_PREVAL;
        else if (c == letok_pkg::CH_QUOTE) nxt = letok_pkg::ST_QUOTED;
        else if (letok_pkg::is_graph(c)) begin
          nxt  = letok_pkg::ST_BARE;
          kind = letok_pkg::KIND_VALUE;
        end else bad = 1'b1;
      end
      letok_pkg::ST_QUOTED: begin
        if (c == letok_pkg::CH_QUOTE) nxt = letok_pkg::ST_POSTVAL;
        else kind = letok_pkg::KIND_VALUE;
      end
      letok_pkg::ST_BARE: begin
        if (letok_pkg::is_graph(c)) kind = letok_pkg::KIND_VALUE;
        else if (c == letok_pkg::CH_CR) nxt = letok_pkg::ST_CR;
        else if (c == letok_pkg::CH_LF) begin
          nxt  = letok_pkg::ST_START;
          done = 1'b1;
        end else if (letok_pkg::is_space(c)) nxt = letok_pkg::ST_POSTVAL;
        else bad = 1'b1;
      end
      letok_pkg::ST_POSTVAL: begin
        if (c == letok_pkg::CH_LT) nxt = letok_pkg::ST_UNIT;
        else if (c == letok_pkg::CH_CR) nxt = letok_pkg::ST_CR;
        else if (c == letok_pkg::CH_LF) begin
          nxt  = letok_pkg::ST_START;
          done = 1'b1;
        end else if (letok_pkg::is_space(c)) nxt = letok_pkg::ST_POSTVAL;
        else bad = 1'b1;
      end
      letok_pkg::ST_UNIT: begin
        if (c == letok_pkg::CH_GT) nxt = letok_pkg::ST_POSTUNT;
        else if (letok_pkg::is_graph(c)) kind = letok_pkg::KIND_UNIT;
        else bad = 1'b1;
      end
      letok_pkg::ST_POSTUNT: begin
        if (c == letok_pkg::CH_CR) nxt = letok_pkg::ST_CR;
        else if (c == letok_pkg::CH_LF) begin
          nxt  = letok_pkg::ST_START;
          done = 1'b1;
        end else bad = 1'b1;
      end
      letok_pkg::ST_CR: begin
        if (c == letok_pkg::CH_LF) begin
          nxt  = letok_pkg::ST_START;
          done = 1'b1;
        end else bad = 1'b1;
      end
      default: begin
        if (letok_pkg::is_space(c)) nxt = letok_pkg::ST_START;
        else if (letok_pkg::is_alpha(c) || c == letok_pkg::CH_CARET) begin
          nxt  = letok_pkg::ST_KEY;
          kind = letok_pkg::KIND_KEY;
        end else bad = 1'b1;
      end
    endcase

    state_d    = state_q;
    halt_d     = halt_q;
    out_char_d = letok_pkg::CH_NUL;
    kind_d     = letok_pkg::KIND_DROP;
    done_d     = 1'b0;

    if (halt_q != letok_pkg::HALT_RUN) begin
      halt_d = halt_q;
    end else if (s1_eoi_q) begin
      halt_d = letok_pkg::HALT_EOI;
    end else if (bad) begin
      halt_d     = letok_pkg::HALT_SYNTAX;
      out_char_d = c;
    end else begin
      state_d    = nxt;
      out_char_d = c;
      kind_d     = kind;
      done_d     = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= letok_pkg::ST_START;
      halt_q      <= letok_pkg::HALT_RUN;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
        halt_q  <= halt_d;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_char_q <= out_char_d;
      kind_q     <= kind_d;
      done_q     <= done_d;
      status_q   <= halt_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_char     = out_char_q;
  assign out_o.char_kind    = kind_q;
  assign out_o.element_done = done_q;
  assign out_o.halt_status  = status_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halt_q != letok_pkg::HALT_RUN) |=> (halt_q == $past(halt_q)))
    else $error("halt code changed after halting");

  a_done_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |->
      (status_q == letok_pkg::HALT_RUN && kind_q == letok_pkg::KIND_DROP &&
       out_char_q == letok_pkg::CH_LF))
    else $error("element end on a word that is not a running line feed");

  a_halted_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != letok_pkg::HALT_RUN) |->
      (kind_q == letok_pkg::KIND_DROP && !done_q))
    else $error("halted word carries text");

  a_state_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halt_q != letok_pkg::HALT_RUN) |=> $stable(state_q))
    else $error("parser state moved while halted");

endmodule

// ----- bench/tb_label_element_tokenizer_unit.sv -----
`timescale 1ns / 100ps

module tb_label_element_tokenizer_unit;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam int STALL_LIMIT      = 2000;
  localparam int RANDOM_WORDS     = 1400;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] kind;
    logic       done;
    logic [1:0] halt;
  } tag_t;

  class tag_tracker;
    letok_pkg::parse_state_e state;
    letok_pkg::halt_e        halt;
    tag_t                    expected_tags[$];
    int                      failures;
    int                      checked;
    int                      elements;
    int                      key_chars;
    int                      value_chars;
    int                      unit_chars;

    function new();
      state = letok_pkg::ST_START;
      halt  = letok_pkg::HALT_RUN;
    endfunction

    function bit ws_char(logic [7:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == CH_SPACE;
    endfunction

    function bit letter_char(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit print_char(logic [7:0] c);
      return c >= 8'd33 && c <= 8'd126;
    endfunction

    // accepted input word -> expected tag
    function void note_byte(logic [7:0] c, logic eoi);
      tag_t                    t = '0;
      letok_pkg::parse_state_e nxt = state;
      letok_pkg::char_kind_e   kind = letok_pkg::KIND_DROP;
      logic                    done = 1'b0;
      bit                      bad = 1'b0;

      if (halt != letok_pkg::HALT_RUN) begin
        t.halt = halt;
        expected_tags.push_back(t);
        return;
      end
      if (eoi) begin
        halt = letok_pkg::HALT_EOI;
        t.halt = halt;
        expected_tags.push_back(t);
        return;
      end
      case (state)
        letok_pkg::ST_KEY: begin
          if (ws_char(c)) nxt = letok_pkg::ST_PREEQ;
          else if (letter_char(c) || c == letok_pkg::CH_UNDER) kind = letok_pkg::KIND_KEY;
          else bad = 1'b1;
        end
        letok_pkg::ST_PREEQ: begin
          if (ws_char(c)) nxt = letok_pkg::ST_PREEQ;
          else if (c == letok_pkg::CH_EQ) nxt = letok_pkg::ST_PREVAL;
          else bad = 1'b1;
        end
        letok_pkg::ST_PREVAL: begin
          if (ws_char(c)) nxt = letok_pkg::ST_PREVAL;
          else if (c == letok_pkg::CH_QUOTE) nxt = letok_pkg::ST_QUOTED;
          else if (print_char(c)) begin
            nxt  = letok_pkg::ST_BARE;
            kind = letok_pkg::KIND_VALUE;
          end else bad = 1'b1;
        end
        letok_pkg::ST_QUOTED: begin
          if (c == letok_pkg::CH_QUOTE) nxt = letok_pkg::ST_POSTVAL;
          else kind = letok_pkg::KIND_VALUE;
        end
        letok_pkg::ST_BARE: begin
          if (print_char(c)) kind = letok_pkg::KIND_VALUE;
          else if (c == letok_pkg::CH_CR) nxt = letok_pkg::ST_CR;
          else if (c == letok_pkg::CH_LF) begin
            nxt  = letok_pkg::ST_START;
            done = 1'b1;
          end else if (ws_char(c)) nxt = letok_pkg::ST_POSTVAL;
          else bad = 1'b1;
        end
        letok_pkg::ST_POSTVAL: begin
          if (c == letok_pkg::CH_LT) nxt = letok_pkg::ST_UNIT;
          else if (c == letok_pkg::CH_CR) nxt = letok_pkg::ST_CR;
          else if (c == letok_pkg::CH_LF) begin
            nxt  = letok_pkg::ST_START;
            done = 1'b1;
          end else if (ws_char(c)) nxt = letok_pkg::ST_POSTVAL;
          else bad = 1'b1;
        end
        letok_pkg::ST_UNIT: begin
          if (c == letok_pkg::CH_GT) nxt = letok_pkg::ST_POSTUNT;
          else if (print_char(c)) kind = letok_pkg::KIND_UNIT;
          else bad = 1'b1;
        end
        letok_pkg::ST_POSTUNT: begin
          if (c == letok_pkg::CH_CR) nxt = letok_pkg::ST_CR;
          else if (c == letok_pkg::CH_LF) begin
            nxt  = letok_pkg::ST_START;
            done = 1'b1;
          end else bad = 1'b1;
        end
        letok_pkg::ST_CR: begin
          if (c == letok_pkg::CH_LF) begin
            nxt  = letok_pkg::ST_START;
            done = 1'b1;
          end else bad = 1'b1;
        end
        default: begin
          if (ws_char(c)) nxt = letok_pkg::ST_START;
          else if (letter_char(c) || c == letok_pkg::CH_CARET) begin
            nxt  = letok_pkg::ST_KEY;
            kind = letok_pkg::KIND_KEY;
          end else bad = 1'b1;
        end
      endcase
      if (bad) begin
        halt = letok_pkg::HALT_SYNTAX;
        kind = letok_pkg::KIND_DROP;
        done = 1'b0;
      end else begin
        state = nxt;
      end
      t.ch   = c;
      t.kind = kind;
      t.done = done;
      t.halt = halt;
      elements    += done;
      key_chars   += (kind == letok_pkg::KIND_KEY);
      value_chars += (kind == letok_pkg::KIND_VALUE);
      unit_chars  += (kind == letok_pkg::KIND_UNIT);
      expected_tags.push_back(t);
    endfunction

    function void check_tag(tag_t got);
      tag_t want;
      if (expected_tags.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result word: char %02h kind %0d done %0d halt %0d",
                   got.ch, got.kind, got.done, got.halt);
        return;
      end
      want = expected_tags.pop_front();
      checked++;
      if (got.ch !== want.ch || got.kind !== want.kind || got.done !== want.done ||
          got.halt !== want.halt) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch at result %0d: char %02h/%02h kind %0d/%0d",
                    " done %0d/%0d halt %0d/%0d"},
                   checked, want.ch, got.ch, want.kind, got.kind, want.done, got.done,
                   want.halt, got.halt);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  letok_in_if  in_if ();
  letok_out_if out_if ();

  label_element_tokenizer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  tag_tracker tags = new();
  logic [7:0] line_q[$];
  int         words_sent;
  bit         send_calm;

  function automatic logic [7:0] pick_blank(bit with_breaks);
    int k;
    k = $urandom_range(0, with_breaks ? 5 : 3);
    case (k)
      0: return CH_TAB;
      1: return CH_VT;
      2: return CH_FF;
      3: return CH_SPACE;
      4: return letok_pkg::CH_CR;
      default: return letok_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
  endfunction

  function automatic logic [7:0] pick_print(logic [7:0] skip);
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (c == skip);
    return c;
  endfunction

  // one well-formed line into line_q
  function automatic void compose_element();
    bit         quoted;
    bit         has_unit;
    int         blanks;
    logic [7:0] b;
    line_q.delete();
    repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank(1'b1));
    line_q.push_back(($urandom_range(0, 6) == 0) ? letok_pkg::CH_CARET : pick_letter());
    repeat ($urandom_range(0, 8))
      line_q.push_back(($urandom_range(0, 4) == 0) ? letok_pkg::CH_UNDER : pick_letter());
    repeat ($urandom_range(1, 3)) line_q.push_back(pick_blank(1'b1));
    line_q.push_back(letok_pkg::CH_EQ);
    repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank(1'b1));
    quoted = ($urandom_range(0, 2) == 0);
    if (quoted) begin
      line_q.push_back(letok_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 10)) begin
        do b = 8'($urandom_range(0, 255)); while (b == letok_pkg::CH_QUOTE);
        line_q.push_back(b);
      end
      line_q.push_back(letok_pkg::CH_QUOTE);
    end else begin
      line_q.push_back(pick_print(letok_pkg::CH_QUOTE));
      repeat ($urandom_range(0, 9)) line_q.push_back(pick_print(8'h00));
    end
    has_unit = 1'($urandom_range(0, 1));
    blanks = $urandom_range(0, 2);
    if (!quoted && has_unit && blanks == 0) blanks = 1;
    repeat (blanks) line_q.push_back(pick_blank(1'b0));
    if (has_unit) begin
      line_q.push_back(letok_pkg::CH_LT);
      repeat ($urandom_range(0, 5)) line_q.push_back(pick_print(letok_pkg::CH_GT));
      line_q.push_back(letok_pkg::CH_GT);
    end
    if ($urandom_range(0, 1)) line_q.push_back(letok_pkg::CH_CR);
    line_q.push_back(letok_pkg::CH_LF);
  endfunction

  task automatic send_word(logic [7:0] b, logic eoi);
    int gap;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.in_byte      <= b;
    in_if.end_of_input <= eoi;
    do @(posedge clk_i); while (!in_if.ready);
    tags.note_byte(b, eoi);
    words_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (tags.expected_tags.size() != 0);
  endtask

  initial begin : stimulus
    bit paused_mid;
    bit end_by_error;
    int cut;
    int n;
    in_if.valid        <= 1'b0;
    in_if.in_byte      <= 8'h00;
    in_if.end_of_input <= 1'b0;
    rst_ni             <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // blank line, caret key, tab, quoted extremes with CR LF inside, unit, lone LF
    line_q = '{letok_pkg::CH_LF, letok_pkg::CH_CARET, "A", letok_pkg::CH_UNDER, CH_SPACE,
               letok_pkg::CH_EQ, CH_TAB, letok_pkg::CH_QUOTE, 8'h00, 8'hFF,
               letok_pkg::CH_CR, letok_pkg::CH_LF, letok_pkg::CH_QUOTE, CH_SPACE, CH_SPACE,
               letok_pkg::CH_LT, "m", letok_pkg::CH_GT, letok_pkg::CH_CR, letok_pkg::CH_LF,
               "z", CH_SPACE, letok_pkg::CH_EQ, "7", letok_pkg::CH_LF};
    foreach (line_q[i]) send_word(line_q[i], 1'b0);
    drain_results();

    while (words_sent < RANDOM_WORDS) begin
      compose_element();
      foreach (line_q[i]) send_word(line_q[i], 1'b0);
      if (!paused_mid && words_sent > RANDOM_WORDS / 2) begin
        paused_mid = 1'b1;
        drain_results();
      end
    end

    // partial line, then either a broken byte stream or end of file
    compose_element();
    cut = $urandom_range(0, line_q.size() - 1);
    for (int i = 0; i < cut; i++) send_word(line_q[i], 1'b0);
    end_by_error = 1'($urandom_range(0, 1));
    n = 0;
    while (end_by_error && tags.halt == letok_pkg::HALT_RUN && n < 600) begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
      n++;
    end
    if (tags.halt == letok_pkg::HALT_RUN) send_word(8'($urandom_range(0, 255)), 1'b1);
    send_word(8'($urandom_range(0, 255)), 1'b1);
    repeat (20) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    drain_results();
    repeat (8) @(posedge clk_i);
    if (tags.expected_tags.size() != 0) tags.failures++;
    $display("sent %0d words, checked %0d results: %0d elements, %0d key/%0d value/%0d unit",
             words_sent, tags.checked, tags.elements, tags.key_chars, tags.value_chars,
             tags.unit_chars);
    $display("run ended halted by %s",
             (tags.halt == letok_pkg::HALT_SYNTAX) ? "syntax error" : "end of input");
    if (tags.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_sink
    tag_t got;
    int   gap;
    bit   held;
    bit   calm;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (!held && tags.checked >= 400) begin
        held = 1'b1;
        gap  = 90;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got.ch   = out_if.out_char;
      got.kind = out_if.char_kind;
      got.done = out_if.element_done;
      got.halt = out_if.halt_status;
      tags.check_tag(got);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
